### rtl/atn_pkg.sv
// ----------------------------------------------------------------------------
// atn_pkg: shared types and constants of the adaptive threshold neuron
// Register indexes, channel word types, sequencer states and the Q0.16
// sigmoid table used to slide the firing level.
// ----------------------------------------------------------------------------
`default_nettype none

package atn_pkg;

   localparam int SPIKE_WIDTH     = 16;
   localparam int LEVEL_WIDTH     = 16;
   localparam int COUNT_WIDTH     = 16;
   localparam int THRESH_WIDTH    = 15;
   localparam int ACTIVE_WIDTH    = 5;
   localparam int POP_WIDTH       = 5;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 16;

   // Cell geometry
   localparam int INPUT_COUNT  = 16;
   localparam int SIGMOID_SPAN = 32;

   // Register indexes on the configuration channel
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LEARN_THRESHOLD = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MIN_LEVEL       = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAX_LEVEL       = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ACTIVE_INPUTS   = 8'd3;

   localparam logic [ACTIVE_WIDTH-1:0] ACTIVE_INPUTS_RESET = 5'd16;

   // Sigmoid argument clamp, taken from the span
   localparam logic signed [17:0] SIG_LO = 18'(-(SIGMOID_SPAN / 2));
   localparam logic signed [17:0] SIG_HI = 18'((SIGMOID_SPAN / 2) - 1);
   localparam logic signed [17:0] TABLE_LO = -18'sd16;
   localparam logic signed [17:0] TABLE_HI = 18'sd15;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEVEL,
      ST_SCALE,
      ST_UPDATE
   } atn_state_type;

   typedef struct packed {
      logic [THRESH_WIDTH-1:0] learn_threshold;
      logic [LEVEL_WIDTH-1:0]  min_level;
      logic [LEVEL_WIDTH-1:0]  max_level;
      logic [ACTIVE_WIDTH-1:0] active_inputs;
   } atn_cfg_type;

   typedef struct packed {
      logic                   fire;
      logic                   above_level;
      logic                   learned_hit;
      logic                   adapted_flag;
      logic [COUNT_WIDTH-1:0] learn_count_out;
      logic [COUNT_WIDTH-1:0] repeat_count_out;
   } atn_result_type;

   // 1/(1+e^x) in Q0.16 for x = -16 .. 15
   function automatic logic [LEVEL_WIDTH-1:0] sig_table(input logic [4:0] idx);
      logic [LEVEL_WIDTH-1:0] v;
      unique case (idx)
         5'd0:  v = 16'd65535;
         5'd1:  v = 16'd65535;
         5'd2:  v = 16'd65535;
         5'd3:  v = 16'd65535;
         5'd4:  v = 16'd65535;
         5'd5:  v = 16'd65535;
         5'd6:  v = 16'd65533;
         5'd7:  v = 16'd65528;
         5'd8:  v = 16'd65514;
         5'd9:  v = 16'd65476;
         5'd10: v = 16'd65374;
         5'd11: v = 16'd65097;
         5'd12: v = 16'd64357;
         5'd13: v = 16'd62428;
         5'd14: v = 16'd57724;
         5'd15: v = 16'd47911;
         5'd16: v = 16'd32768;
         5'd17: v = 16'd17625;
         5'd18: v = 16'd7812;
         5'd19: v = 16'd3108;
         5'd20: v = 16'd1179;
         5'd21: v = 16'd439;
         5'd22: v = 16'd162;
         5'd23: v = 16'd60;
         5'd24: v = 16'd22;
         5'd25: v = 16'd8;
         5'd26: v = 16'd3;
         5'd27: v = 16'd1;
         5'd28: v = 16'd0;
         5'd29: v = 16'd0;
         5'd30: v = 16'd0;
         5'd31: v = 16'd0;
      endcase
      return v;
   endfunction

   // Clamp to the span, saturate outside the table, else look up
   function automatic logic [LEVEL_WIDTH-1:0] sigmoid_q16(input logic signed [17:0] x);
      logic signed [17:0] xc;
      logic [17:0]        idx;
      xc = x;
      if (xc < SIG_LO) xc = SIG_LO;
      if (xc > SIG_HI) xc = SIG_HI;
      idx = 18'(xc - TABLE_LO);
      if (xc < TABLE_LO) begin
         return 16'hFFFF;
      end else if (xc > TABLE_HI) begin
         return 16'h0000;
      end else begin
         return sig_table(idx[4:0]);
      end
   endfunction

endpackage

`default_nettype wire

### rtl/atn_ifs.sv
// ----------------------------------------------------------------------------
// atn_ifs: channel interfaces of the adaptive threshold neuron
// Tick request, tick response and register write channels, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface atn_req_if;
   logic                             valid;
   logic                             ready;
   logic [atn_pkg::SPIKE_WIDTH-1:0]  spike_bits;
   logic                             inhibit;

   modport source (output valid, output spike_bits, output inhibit, input ready);
   modport sink   (input valid, input spike_bits, input inhibit, output ready);
endinterface

interface atn_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             fire;
   logic                             above_level;
   logic                             learned_hit;
   logic                             adapted_flag;
   logic [atn_pkg::COUNT_WIDTH-1:0]  learn_count_out;
   logic [atn_pkg::COUNT_WIDTH-1:0]  repeat_count_out;

   modport source (output valid, output fire, output above_level, output learned_hit,
                   output adapted_flag, output learn_count_out, output repeat_count_out,
                   input ready);
   modport sink   (input valid, input fire, input above_level, input learned_hit,
                   input adapted_flag, input learn_count_out, input repeat_count_out,
                   output ready);
endinterface

interface atn_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [atn_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [atn_pkg::CSR_DATA_WIDTH-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/atn_core.sv
// ----------------------------------------------------------------------------
// atn_core: tick sequencer and shared multiplier
// Looks up the sigmoid on acceptance, then runs the level and scale products
// through one 16x16 multiplier and commits the cell state on the last step.
// ----------------------------------------------------------------------------
`default_nettype none

module atn_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire atn_pkg::atn_cfg_type            cfg,
   input  wire logic                            item_valid,
   output logic                                 item_ready,
   input  wire logic [atn_pkg::SPIKE_WIDTH-1:0] item_spike_bits,
   input  wire logic                            item_inhibit,
   output logic                                 result_valid,
   input  wire logic                            result_ready,
   output atn_pkg::atn_result_type              result
);

   localparam int N_MAX = (atn_pkg::INPUT_COUNT < atn_pkg::SPIKE_WIDTH) ?
                          atn_pkg::INPUT_COUNT : atn_pkg::SPIKE_WIDTH;
   localparam int LW = atn_pkg::LEVEL_WIDTH;
   localparam int CW = atn_pkg::COUNT_WIDTH;
   localparam int SCALE_WIDTH = LW + atn_pkg::POP_WIDTH;

   atn_pkg::atn_state_type state_ff, state_in;

   logic [CW-1:0] learn_count_ff, learn_count_in;
   logic [CW-1:0] repeat_count_ff, repeat_count_in;
   logic          adapted_ff, adapted_in;
   logic          output_hold_ff, output_hold_in;

   logic [LW-1:0]                    sig_ff, sig_in;
   logic [atn_pkg::POP_WIDTH-1:0]    pop_ff, pop_in;
   logic                             inhibit_ff, inhibit_in;
   logic [LW-1:0]                    level_ff, level_in;
   logic [SCALE_WIDTH-1:0]           scaled_ff, scaled_in;

   logic [atn_pkg::ACTIVE_WIDTH-1:0] n_eff;
   logic [atn_pkg::SPIKE_WIDTH-1:0]  masked;
   logic [atn_pkg::POP_WIDTH-1:0]    pop_now;
   logic signed [17:0]               sig_arg;
   logic                             level_up;
   logic [LW-1:0]                    level_span;
   logic [LW-1:0]                    mul_a, mul_b;
   logic [2*LW-1:0]                  product, rounded;
   logic [LW-1:0]                    level_new;
   logic                             above;
   logic [CW-1:0]                    learn_next;
   logic                             hit;

   // Operand conditioning and the shared multiplier
   always_comb begin
      if (cfg.active_inputs == '0) begin
         n_eff = atn_pkg::ACTIVE_WIDTH'(1);
      end else if (cfg.active_inputs > atn_pkg::ACTIVE_WIDTH'(N_MAX)) begin
         n_eff = atn_pkg::ACTIVE_WIDTH'(N_MAX);
      end else begin
         n_eff = cfg.active_inputs;
      end
      for (int i = 0; i < atn_pkg::SPIKE_WIDTH; i++) begin
         masked[i] = item_spike_bits[i] && (atn_pkg::ACTIVE_WIDTH'(i) < n_eff);
      end
      pop_now = '0;
      for (int i = 0; i < atn_pkg::SPIKE_WIDTH; i++) begin
         pop_now = pop_now + atn_pkg::POP_WIDTH'(masked[i]);
      end

      // learn_count minus twice the learn threshold
      sig_arg = $signed({2'b00, learn_count_ff}) - $signed({2'b00, cfg.learn_threshold, 1'b0});

      level_up   = cfg.max_level >= cfg.min_level;
      level_span = level_up ? (cfg.max_level - cfg.min_level)
                            : (cfg.min_level - cfg.max_level);

      if (state_ff == atn_pkg::ST_SCALE) begin
         mul_a = level_ff;
         mul_b = LW'(n_eff);
      end else begin
         mul_a = sig_ff;
         mul_b = level_span;
      end
      product = mul_a * mul_b;

      // round to nearest; cannot carry out of 32 bits
      rounded   = product + (2*LW)'(32768);
      level_new = level_up ? (cfg.min_level + rounded[2*LW-1:LW])
                           : (cfg.min_level - rounded[2*LW-1:LW]);

      above = {pop_ff, {LW{1'b0}}} >= scaled_ff;
      if (above && (learn_count_ff != {CW{1'b1}})) begin
         learn_next = learn_count_ff + CW'(1);
      end else begin
         learn_next = learn_count_ff;
      end
      hit = above && (learn_next >= CW'(cfg.learn_threshold));
   end

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      learn_count_in  = learn_count_ff;
      repeat_count_in = repeat_count_ff;
      adapted_in      = adapted_ff;
      output_hold_in  = output_hold_ff;
      sig_in          = sig_ff;
      pop_in          = pop_ff;
      inhibit_in      = inhibit_ff;
      level_in        = level_ff;
      scaled_in       = scaled_ff;
      item_ready      = 1'b0;
      result_valid    = 1'b0;

      unique case (state_ff)
         atn_pkg::ST_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               sig_in     = atn_pkg::sigmoid_q16(sig_arg);
               pop_in     = pop_now;
               inhibit_in = item_inhibit;
               state_in   = atn_pkg::ST_LEVEL;
            end
         end
         atn_pkg::ST_LEVEL: begin
            level_in = level_new;
            state_in = atn_pkg::ST_SCALE;
         end
         atn_pkg::ST_SCALE: begin
            scaled_in = product[SCALE_WIDTH-1:0];
            state_in  = atn_pkg::ST_UPDATE;
         end
         atn_pkg::ST_UPDATE: begin
            result_valid = 1'b1;
            // hold here until the output register can take the word
            if (result_ready) begin
               learn_count_in = learn_next;
               if (hit) begin
                  adapted_in = 1'b1;
                  if (repeat_count_ff != {CW{1'b1}}) begin
                     repeat_count_in = repeat_count_ff + CW'(1);
                  end
               end
               if (inhibit_ff) begin
                  output_hold_in = 1'b0;
               end else if (hit) begin
                  output_hold_in = 1'b1;
               end
               state_in = atn_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = atn_pkg::ST_IDLE;
         end
      endcase

      result.fire             = inhibit_ff ? 1'b0 : (hit | output_hold_ff);
      result.above_level      = above;
      result.learned_hit      = hit;
      result.adapted_flag     = adapted_ff | hit;
      result.learn_count_out  = learn_next;
      result.repeat_count_out = (hit && (repeat_count_ff != {CW{1'b1}})) ?
                                (repeat_count_ff + CW'(1)) : repeat_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= atn_pkg::ST_IDLE;
         learn_count_ff  <= '0;
         repeat_count_ff <= '0;
         adapted_ff      <= 1'b0;
         output_hold_ff  <= 1'b0;
      end else begin
         state_ff        <= state_in;
         learn_count_ff  <= learn_count_in;
         repeat_count_ff <= repeat_count_in;
         adapted_ff      <= adapted_in;
         output_hold_ff  <= output_hold_in;
      end
   end

   always_ff @(posedge clock) begin
      sig_ff     <= sig_in;
      pop_ff     <= pop_in;
      inhibit_ff <= inhibit_in;
      level_ff   <= level_in;
      scaled_ff  <= scaled_in;
   end

   // Cell state moves only on the commit step
   assert property (@(posedge clock) disable iff (reset)
      !(state_ff == atn_pkg::ST_UPDATE && result_ready) |=>
         $stable(learn_count_ff) && $stable(repeat_count_ff))
      else $error("cell counters changed outside a commit");

   assert property (@(posedge clock) disable iff (reset)
      adapted_ff |=> adapted_ff)
      else $error("adapted flag dropped");

   assert property (@(posedge clock) disable iff (reset)
      (repeat_count_ff != '0) |-> adapted_ff)
      else $error("repeat count moved on a cell that never adapted");

   assert property (@(posedge clock) disable iff (reset)
      output_hold_ff |-> adapted_ff)
      else $error("output set on a cell that never adapted");

endmodule

`default_nettype wire

### rtl/adaptive_threshold_neuron.sv
// ----------------------------------------------------------------------------
// adaptive_threshold_neuron: spiking cell with a sigmoidally adapting level
// Configuration registers, output register and the tick sequencer.
// ----------------------------------------------------------------------------
// Usage
//   req_port carries one network tick per word: spike_bits and inhibit.
//   rsp_port returns one word per tick: fire, above_level, learned_hit,
//   adapted_flag and the two counters after the update.
//   csr_port writes learn_threshold (0), min_level (1), max_level (2) and
//   active_inputs (3); other indexes are ignored. Always ready. Write only
//   while no tick is in flight.
// Timing
//   A tick runs through the accept step (sigmoid lookup and spike count),
//   the level product, the scale product and the compare/commit step. Both
//   products share one 16x16 multiplier, so they take separate steps. The
//   response enters the output register at commit; req_port.ready is low
//   from acceptance until commit.
//   The response sits in an output register. A stalled receiver holds the
//   next tick in its commit step until that register frees.
// Reset
//   Synchronous: counters, flags and configuration registers clear, active_inputs goes to
//   16, the output register empties.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_threshold_neuron (
   input  wire logic clock,
   input  wire logic reset,
   atn_req_if.sink   req_port,
   atn_rsp_if.source rsp_port,
   atn_csr_if.sink   csr_port
);

   atn_pkg::atn_cfg_type    cfg_ff, cfg_in;
   atn_pkg::atn_result_type rsp_data_ff, rsp_data_in;
   atn_pkg::atn_result_type result;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    item_ready;
   logic                    result_valid;
   logic                    result_ready;

   assign csr_port.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_port.valid) begin
         unique case (csr_port.index)
            atn_pkg::REG_LEARN_THRESHOLD:
               cfg_in.learn_threshold = csr_port.data[atn_pkg::THRESH_WIDTH-1:0];
            atn_pkg::REG_MIN_LEVEL:
               cfg_in.min_level = csr_port.data[atn_pkg::LEVEL_WIDTH-1:0];
            atn_pkg::REG_MAX_LEVEL:
               cfg_in.max_level = csr_port.data[atn_pkg::LEVEL_WIDTH-1:0];
            atn_pkg::REG_ACTIVE_INPUTS:
               cfg_in.active_inputs = csr_port.data[atn_pkg::ACTIVE_WIDTH-1:0];
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   atn_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .item_valid      (req_port.valid),
      .item_ready      (item_ready),
      .item_spike_bits (req_port.spike_bits),
      .item_inhibit    (req_port.inhibit),
      .result_valid    (result_valid),
      .result_ready    (result_ready),
      .result          (result)
   );

   assign req_port.ready = item_ready;

   // Output register: take a new word when empty or being emptied
   assign result_ready = !rsp_valid_ff || rsp_port.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result_valid && result_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.learn_threshold <= '0;
         cfg_ff.min_level       <= '0;
         cfg_ff.max_level       <= '0;
         cfg_ff.active_inputs   <= atn_pkg::ACTIVE_INPUTS_RESET;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff                 <= cfg_in;
         rsp_valid_ff           <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_port.valid            = rsp_valid_ff;
   assign rsp_port.fire             = rsp_data_ff.fire;
   assign rsp_port.above_level      = rsp_data_ff.above_level;
   assign rsp_port.learned_hit      = rsp_data_ff.learned_hit;
   assign rsp_port.adapted_flag     = rsp_data_ff.adapted_flag;
   assign rsp_port.learn_count_out  = rsp_data_ff.learn_count_out;
   assign rsp_port.repeat_count_out = rsp_data_ff.repeat_count_out;

endmodule

`default_nettype wire
